FILE: rtl/double_ended_queue_core_macros.svh
// Assertion macros for the double-ended queue core.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define DQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/dq_pkg.sv
// Shared types and constants for the double-ended queue core.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package dq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int WORD_W        = 32;
  localparam int OCC_W         = 5;

  // Opcodes; codes above LOOK act as LOOK
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_REAR   = 3'd3;
  localparam logic [2:0] OP_LOOK       = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [WORD_W-1:0] value;
  } dq_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic [OCC_W-1:0]         occupancy;
  } dq_out_t;

  // Per-cycle command broadcast to every cell of a chain.
  // ins: shift toward the tail and place word at the head.
  // app: place word in the first free cell.
  // del_head: shift toward the head. del_tail: free the last occupied cell.
  typedef struct packed {
    logic              ins;
    logic              app;
    logic              del_head;
    logic              del_tail;
    logic [WORD_W-1:0] word;
  } dq_ctrl_t;

endpackage

FILE: rtl/double_ended_queue_core.sv
// Double-ended queue of signed 32-bit words, DEPTH entries. Storage is two
// rows of DEPTH cells, one with the front word at its head and one with the
// rear word at its head, cells shifting on pushes and pops at the head, so
// front and rear are always read from a fixed cell. One transaction is taken
// per cycle; its result appears in the output register on the next cycle and
// holds while out_stall is high, which also stalls the input. Every
// transaction yields one result with status, front and rear words (all ones
// when empty) and occupancy. No clearing pass is needed after reset.
// Depends on dq_pkg, dq_chain and double_ended_queue_core_macros.svh.
`timescale 1ns / 1ps
`include "double_ended_queue_core_macros.svh"

module double_ended_queue_core #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  dq_pkg::dq_in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output dq_pkg::dq_out_t out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic             in_acc;
  logic             empty;
  logic             full;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [1:0]       status_r;
  logic [1:0]       status_nxt;
  logic             out_valid_r;
  logic             do_push_f;
  logic             do_push_r;
  logic             do_pop_f;
  logic             do_pop_r;
  logic             do_push_any;

  dq_pkg::dq_ctrl_t          f_ctrl;
  dq_pkg::dq_ctrl_t          r_ctrl;
  logic                      f_head_occ;
  logic                      r_head_occ;
  logic [dq_pkg::WORD_W-1:0] f_head;
  logic [dq_pkg::WORD_W-1:0] r_head;

  // Handshake: the result register parts the two sides
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(DEPTH));

  // Decode the transaction into legal moves and status
  always_comb begin
    do_push_f  = 1'b0;
    do_push_r  = 1'b0;
    do_pop_f   = 1'b0;
    do_pop_r   = 1'b0;
    status_nxt = dq_pkg::ST_OK;
    unique case (in_data.opcode)
      dq_pkg::OP_PUSH_FRONT: begin
        if (full) status_nxt = dq_pkg::ST_FULL;
        else      do_push_f  = in_acc;
      end
      dq_pkg::OP_PUSH_REAR: begin
        if (full) status_nxt = dq_pkg::ST_FULL;
        else      do_push_r  = in_acc;
      end
      dq_pkg::OP_POP_FRONT: begin
        if (empty) status_nxt = dq_pkg::ST_EMPTY;
        else       do_pop_f   = in_acc;
      end
      dq_pkg::OP_POP_REAR: begin
        if (empty) status_nxt = dq_pkg::ST_EMPTY;
        else       do_pop_r   = in_acc;
      end
      default: begin
        if (empty) status_nxt = dq_pkg::ST_EMPTY;
      end
    endcase
  end

  assign do_push_any = do_push_f | do_push_r;

  // Front row: head is the front word; rear row mirrors it
  always_comb begin
    f_ctrl.ins      = do_push_f;
    f_ctrl.app      = do_push_r;
    f_ctrl.del_head = do_pop_f;
    f_ctrl.del_tail = do_pop_r;
    f_ctrl.word     = in_data.value;
    r_ctrl.ins      = do_push_r;
    r_ctrl.app      = do_push_f;
    r_ctrl.del_head = do_pop_r;
    r_ctrl.del_tail = do_pop_f;
    r_ctrl.word     = in_data.value;
  end

  // Occupancy counter
  always_comb begin
    count_nxt = count_r;
    if (do_push_f || do_push_r) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop_f || do_pop_r) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r <= status_nxt;
    end
  end

  dq_chain #(.DEPTH(DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (f_ctrl),
    .head_occ  (f_head_occ),
    .head_data (f_head)
  );

  dq_chain #(.DEPTH(DEPTH)) u_rear (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (r_ctrl),
    .head_occ  (r_head_occ),
    .head_data (r_head)
  );

  // Result fields come straight from registers, so they hold under stall
  assign out_valid            = out_valid_r;
  assign out_data.status      = status_r;
  assign out_data.front_value = empty ? dq_pkg::EMPTY_WORD : f_head;
  assign out_data.rear_value  = empty ? dq_pkg::EMPTY_WORD : r_head;
  assign out_data.occupancy   = dq_pkg::OCC_W'(count_r);

  // Checks
  `DQ_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH), "occupancy above depth")
  `DQ_ASSERT(a_rows_agree, (f_head_occ == !empty) && (r_head_occ == !empty), "rows vs count")
  `DQ_ASSERT(a_single_same, (count_r == CNT_W'(1)) |-> (f_head == r_head), "front/rear differ")
  `DQ_ASSERT_NEXT(a_push_grows, do_push_any, count_r == $past(count_r) + CNT_W'(1), "push lost")

endmodule

FILE: rtl/dq_cell.sv
// One storage cell of a deque chain: a word plus an occupied flag.
// Depends on dq_pkg for the command struct.
`timescale 1ns / 1ps

module dq_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dq_pkg::dq_ctrl_t          ctrl,
  input  logic                      left_occ,
  input  logic [dq_pkg::WORD_W-1:0] left_data,
  input  logic                      right_occ,
  input  logic [dq_pkg::WORD_W-1:0] right_data,
  output logic                      occ,
  output logic [dq_pkg::WORD_W-1:0] data
);

  logic                      occ_r;
  logic                      occ_nxt;
  logic [dq_pkg::WORD_W-1:0] data_r;
  logic [dq_pkg::WORD_W-1:0] data_nxt;

  // Local update from the neighbors; commands are mutually exclusive
  always_comb begin
    occ_nxt  = occ_r;
    data_nxt = data_r;
    priority if (ctrl.ins) begin
      occ_nxt  = occ_r | left_occ;
      data_nxt = left_data;
    end else if (ctrl.app) begin
      occ_nxt = occ_r | left_occ;
      if (!occ_r && left_occ) begin
        data_nxt = ctrl.word;
      end
    end else if (ctrl.del_head) begin
      occ_nxt  = right_occ;
      data_nxt = right_data;
    end else if (ctrl.del_tail) begin
      occ_nxt = occ_r & right_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign occ  = occ_r;
  assign data = data_r;

endmodule

FILE: rtl/dq_chain.sv
// A row of DEPTH cells, head at index zero, wired to their neighbors.
// Depends on dq_pkg and dq_cell.
`timescale 1ns / 1ps

module dq_chain #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dq_pkg::dq_ctrl_t          ctrl,
  output logic                      head_occ,
  output logic [dq_pkg::WORD_W-1:0] head_data
);

  logic                      occ  [DEPTH];
  logic [dq_pkg::WORD_W-1:0] data [DEPTH];

  // Head cell sees an always-occupied left neighbor carrying the new word;
  // tail cell sees an empty right neighbor and holds its own word
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      l_occ;
    logic [dq_pkg::WORD_W-1:0] l_data;
    logic                      r_occ;
    logic [dq_pkg::WORD_W-1:0] r_data;

    if (i == 0) begin : g_head
      assign l_occ  = 1'b1;
      assign l_data = ctrl.word;
    end else begin : g_mid_l
      assign l_occ  = occ[i-1];
      assign l_data = data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_occ  = 1'b0;
      assign r_data = data[i];
    end else begin : g_mid_r
      assign r_occ  = occ[i+1];
      assign r_data = data[i+1];
    end

    dq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .left_occ   (l_occ),
      .left_data  (l_data),
      .right_occ  (r_occ),
      .right_data (r_data),
      .occ        (occ[i]),
      .data       (data[i])
    );
  end

  assign head_occ  = occ[0];
  assign head_data = data[0];

endmodule
